>>> sv/fixed_point_q24_8_alu_assert.svh
// Assertion macros used by the ALU top module.
`ifndef FIXED_POINT_Q24_8_ALU_ASSERT_SVH
`define FIXED_POINT_Q24_8_ALU_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define FPA_ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// Signal at the end of a chain implies its source a fixed number of cycles before.
`define FPA_ASSERT_PAST(lbl, clk_s, rstn_s, sink, src, dly) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (sink) |-> $past(src, dly)) \
    else $error("assertion failed");

`endif

>>> sv/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Operation codes and side-band types for the fixed-point ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;

  typedef enum logic [3:0] {
    KIND_ADD     = 4'd0,
    KIND_SUB     = 4'd1,
    KIND_MUL     = 4'd2,
    KIND_DIV     = 4'd3,
    KIND_GT      = 4'd4,
    KIND_LT      = 4'd5,
    KIND_GE      = 4'd6,
    KIND_LE      = 4'd7,
    KIND_EQ      = 4'd8,
    KIND_NE      = 4'd9,
    KIND_MAX     = 4'd10,
    KIND_MIN     = 4'd11,
    KIND_INC     = 4'd12,
    KIND_DEC     = 4'd13,
    KIND_TOINT   = 4'd14,
    KIND_FROMINT = 4'd15
  } fpa_kind_t;

  // Result of non-divide kinds plus divide sign/fault info, carried alongside
  // the divider.
  typedef struct packed {
    logic [31:0] value;
    logic        cmp;
    logic        is_div;
    logic        neg;
    logic        dz;
  } fpa_side_t;

endpackage
`default_nettype wire

>>> sv/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front
// Input register, simple ops, multiplier and divide operand prep (3 stages).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module fpa_front #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  fpa_pkg::fpa_kind_t         in_kind,
  input  logic [31:0]                in_a,
  input  logic [31:0]                in_b,
  output logic                       out_valid,
  output fpa_pkg::fpa_side_t         out_side,
  output logic [32+FRACTION_BITS-1:0] out_dvd,
  output logic [31:0]                out_dsr
);
  import fpa_pkg::*;

  localparam int DW = 32 + FRACTION_BITS;

  // stage 1: registered request
  logic        v1_r;
  fpa_kind_t   kind1_r;
  logic [31:0] a1_r, b1_r;

  // stage 2: simple results, raw product, divide operands
  logic              v2_r, v2_nxt;
  fpa_side_t         side2_r, side2_nxt;
  logic              is_mul2_r, is_mul2_nxt;
  logic signed [63:0] prod2_r, prod2_nxt;
  logic [DW-1:0]     dvd2_r, dvd2_nxt;
  logic [31:0]       dsr2_r, dsr2_nxt;

  // stage 3: product scaled into value
  logic          v3_r;
  fpa_side_t     side3_r, side3_nxt;
  logic [DW-1:0] dvd3_r;
  logic [31:0]   dsr3_r;

  logic signed [31:0] sa, sb;
  logic [31:0]        abs_a, abs_b;

  assign sa    = $signed(a1_r);
  assign sb    = $signed(b1_r);
  assign abs_a = a1_r[31] ? (32'd0 - a1_r) : a1_r;
  assign abs_b = b1_r[31] ? (32'd0 - b1_r) : b1_r;

  // stage 2 logic
  always_comb begin
    v2_nxt           = v1_r;
    side2_nxt        = '0;
    is_mul2_nxt      = (kind1_r == KIND_MUL);
    prod2_nxt        = 64'(sa) * 64'(sb);
    dvd2_nxt         = {abs_a, {FRACTION_BITS{1'b0}}};
    dsr2_nxt         = abs_b;
    side2_nxt.is_div = (kind1_r == KIND_DIV);
    side2_nxt.neg    = a1_r[31] ^ b1_r[31];
    side2_nxt.dz     = (kind1_r == KIND_DIV) && (b1_r == 32'd0);
    case (kind1_r)
      KIND_ADD:     side2_nxt.value = a1_r + b1_r;
      KIND_SUB:     side2_nxt.value = a1_r - b1_r;
      KIND_MUL:     side2_nxt.value = '0;
      KIND_DIV:     side2_nxt.value = '0;
      KIND_GT:      side2_nxt.cmp   = sa > sb;
      KIND_LT:      side2_nxt.cmp   = sa < sb;
      KIND_GE:      side2_nxt.cmp   = sa >= sb;
      KIND_LE:      side2_nxt.cmp   = sa <= sb;
      KIND_EQ:      side2_nxt.cmp   = a1_r == b1_r;
      KIND_NE:      side2_nxt.cmp   = a1_r != b1_r;
      KIND_MAX:     side2_nxt.value = (sa > sb) ? a1_r : b1_r;
      KIND_MIN:     side2_nxt.value = (sa < sb) ? a1_r : b1_r;
      KIND_INC:     side2_nxt.value = a1_r + 32'd1;
      KIND_DEC:     side2_nxt.value = a1_r - 32'd1;
      KIND_TOINT:   side2_nxt.value = 32'(sa >>> FRACTION_BITS);
      KIND_FROMINT: side2_nxt.value = a1_r << FRACTION_BITS;
      default:      side2_nxt.value = '0;
    endcase
  end

  // stage 3 logic: drop fraction bits of the product
  always_comb begin
    side3_nxt = side2_r;
    if (is_mul2_r) begin
      side3_nxt.value = prod2_r[FRACTION_BITS+31:FRACTION_BITS];
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v2_nxt;
      v3_r <= v2_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    kind1_r   <= in_kind;
    a1_r      <= in_a;
    b1_r      <= in_b;
    side2_r   <= side2_nxt;
    is_mul2_r <= is_mul2_nxt;
    prod2_r   <= prod2_nxt;
    dvd2_r    <= dvd2_nxt;
    dsr2_r    <= dsr2_nxt;
    side3_r   <= side3_nxt;
    dvd3_r    <= dvd2_r;
    dsr3_r    <= dsr2_r;
  end

  assign out_valid = v3_r;
  assign out_side  = side3_r;
  assign out_dvd   = dvd3_r;
  assign out_dsr   = dsr3_r;

endmodule
`default_nettype wire

>>> sv/fpa_div_stage.sv
// ----------------------------------------------------------------------------
// fpa_div_stage
// One restoring-division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module fpa_div_stage #(
  parameter int DW = 40
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  fpa_pkg::fpa_side_t in_side,
  input  logic [DW-1:0]      in_dvd,
  input  logic [31:0]        in_dsr,
  input  logic [31:0]        in_rem,
  input  logic [31:0]        in_quo,
  output logic               out_valid,
  output fpa_pkg::fpa_side_t out_side,
  output logic [DW-1:0]      out_dvd,
  output logic [31:0]        out_dsr,
  output logic [31:0]        out_rem,
  output logic [31:0]        out_quo
);
  import fpa_pkg::*;

  logic          valid_r;
  fpa_side_t     side_r;
  logic [DW-1:0] dvd_r;
  logic [31:0]   dsr_r, rem_r, rem_nxt, quo_r, quo_nxt;
  logic [32:0]   trial, diff;

  // shift in next dividend bit, subtract when it fits
  always_comb begin
    trial = {in_rem, in_dvd[DW-1]};
    diff  = trial - {1'b0, in_dsr};
    if (trial >= {1'b0, in_dsr}) begin
      rem_nxt = diff[31:0];
      quo_nxt = {in_quo[30:0], 1'b1};
    end else begin
      rem_nxt = trial[31:0];
      quo_nxt = {in_quo[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    side_r <= in_side;
    dvd_r  <= {in_dvd[DW-2:0], 1'b0};
    dsr_r  <= in_dsr;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
  end

  assign out_valid = valid_r;
  assign out_side  = side_r;
  assign out_dvd   = dvd_r;
  assign out_dsr   = dsr_r;
  assign out_rem   = rem_r;
  assign out_quo   = quo_r;

endmodule
`default_nettype wire

>>> sv/fpa_divider.sv
// ----------------------------------------------------------------------------
// fpa_divider
// Chain of DW division stages; side-band results ride along unchanged.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module fpa_divider #(
  parameter int DW = 40
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  fpa_pkg::fpa_side_t in_side,
  input  logic [DW-1:0]      in_dvd,
  input  logic [31:0]        in_dsr,
  output logic               out_valid,
  output fpa_pkg::fpa_side_t out_side,
  output logic [31:0]        out_quo
);
  import fpa_pkg::*;

  logic          v   [DW+1];
  fpa_side_t     sd  [DW+1];
  logic [DW-1:0] dvd [DW+1];
  logic [31:0]   dsr [DW+1];
  logic [31:0]   rem [DW+1];
  logic [31:0]   quo [DW+1];

  assign v[0]   = in_valid;
  assign sd[0]  = in_side;
  assign dvd[0] = in_dvd;
  assign dsr[0] = in_dsr;
  assign rem[0] = '0;
  assign quo[0] = '0;

  for (genvar i = 0; i < DW; i++) begin : g_stage
    fpa_div_stage #(.DW(DW)) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v[i]),
      .in_side   (sd[i]),
      .in_dvd    (dvd[i]),
      .in_dsr    (dsr[i]),
      .in_rem    (rem[i]),
      .in_quo    (quo[i]),
      .out_valid (v[i+1]),
      .out_side  (sd[i+1]),
      .out_dvd   (dvd[i+1]),
      .out_dsr   (dsr[i+1]),
      .out_rem   (rem[i+1]),
      .out_quo   (quo[i+1])
    );
  end

  assign out_valid = v[DW];
  assign out_side  = sd[DW];
  assign out_quo   = quo[DW];

endmodule
`default_nettype wire

>>> sv/fixed_point_q24_8_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu
// Pipelined signed Q24.8 ALU: arithmetic, comparisons, min/max, conversions.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive in_kind, in_operand_a, in_operand_b with in_start
//   high; the request is taken at any edge where busy is low. busy is never
//   raised, so one request can enter every clock cycle.
//   Result channel: out_strobe is high for exactly one cycle per request,
//   with out_value, out_compare_true and out_divide_by_zero valid in that
//   cycle. Results leave in request order.
//   Every kind takes the same path from accept to strobe: 3 front stages,
//   32 + FRACTION_BITS restoring-division stages, one output register.
//   Throughput: one request per cycle; the division chain, one
//   quotient bit per stage, sets the latency.
//   Reset (rst_n low, synchronous) clears all valid bits; requests in flight
//   are dropped. The receiver cannot stall, so no backpressure exists.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_point_q24_8_alu_assert.svh"
module fixed_point_q24_8_alu #(
  parameter int FRACTION_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_start,
  output logic               busy,
  input  fpa_pkg::fpa_kind_t in_kind,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic               out_strobe,
  output logic signed [31:0] out_value,
  output logic               out_compare_true,
  output logic               out_divide_by_zero
);
  import fpa_pkg::*;

  localparam int DW = 32 + FRACTION_BITS;

  logic          fr_valid, dv_valid;
  fpa_side_t     fr_side, dv_side;
  logic [DW-1:0] fr_dvd;
  logic [31:0]   fr_dsr, dv_quo;

  logic        accept;
  logic        strobe_r;
  logic [31:0] value_r, value_nxt;
  logic        cmp_r, dz_r;

  assign busy   = 1'b0;
  assign accept = in_start && !busy;

  fpa_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_kind   (in_kind),
    .in_a      (in_operand_a),
    .in_b      (in_operand_b),
    .out_valid (fr_valid),
    .out_side  (fr_side),
    .out_dvd   (fr_dvd),
    .out_dsr   (fr_dsr)
  );

  fpa_divider #(.DW(DW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_side   (fr_side),
    .in_dvd    (fr_dvd),
    .in_dsr    (fr_dsr),
    .out_valid (dv_valid),
    .out_side  (dv_side),
    .out_quo   (dv_quo)
  );

  // final select: signed quotient for divide, side value otherwise
  always_comb begin
    value_nxt = dv_side.value;
    if (dv_side.is_div) begin
      if (dv_side.dz) begin
        value_nxt = '0;
      end else if (dv_side.neg) begin
        value_nxt = 32'd0 - dv_quo;
      end else begin
        value_nxt = dv_quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    cmp_r   <= dv_side.cmp;
    dz_r    <= dv_side.dz;
  end

  assign out_strobe         = strobe_r;
  assign out_value          = $signed(value_r);
  assign out_compare_true   = cmp_r;
  assign out_divide_by_zero = dz_r;

  // checks
  `FPA_ASSERT_IMPLY(a_dz_zero, clk, rst_n, out_strobe && out_divide_by_zero, out_value == 32'sd0)
  `FPA_ASSERT_IMPLY(a_flags_excl, clk, rst_n, out_strobe, !(out_compare_true && out_divide_by_zero))
  `FPA_ASSERT_PAST(a_div_chain, clk, rst_n, dv_valid, fr_valid, DW)
  `FPA_ASSERT_PAST(a_latency, clk, rst_n, out_strobe, accept, DW + 4)

endmodule
`default_nettype wire
